### hw/rtl/crtp_pkg.sv
package crtp_pkg;

  localparam int SLOT_W = 6;
  localparam int CRED_W = 8;
  localparam int PRIO_W = 8;

  typedef logic [1:0] func_t;
  localparam func_t FN_SCHED = 2'd0;
  localparam func_t FN_WRITE = 2'd1;
  localparam func_t FN_EXIT  = 2'd2;

  typedef logic [1:0] status_t;
  localparam status_t ST_OK       = 2'd0;
  localparam status_t ST_NONE     = 2'd1;
  localparam status_t ST_NOCREDIT = 2'd2;

  // priority that slot 0 holds out of reset, every other slot holds zero
  localparam logic [PRIO_W-1:0] PRIO_SLOT0_RST = 8'd1;

  typedef struct packed {
    logic [PRIO_W-1:0] prio;
    logic [CRED_W-1:0] cred;
  } slot_row_t;

endpackage

### hw/rtl/credit_refill_task_picker.sv
// Credit-based task picker over TASK_SLOTS slots. Each input beat returns exactly one
// result beat. A write beat updates its slot and then returns its result. A schedule or
// exit beat walks the slot table once through the credit/priority RAM read port; when
// every runnable slot is out of credit a second walk refills and re-picks in the same
// pass. in_ready is high only between beats.
// No clearing pass after reset: a per-slot written flag makes untouched rows read
// as their reset value.
module credit_refill_task_picker
  import crtp_pkg::*;
#(
  parameter int TASK_SLOTS = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        in_func,
  input  logic [SLOT_W-1:0] in_slot,
  input  logic              in_slot_present,
  input  logic              in_slot_running,
  input  logic [CRED_W-1:0] in_credit_value,
  input  logic [PRIO_W-1:0] in_priority_value,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [SLOT_W-1:0] out_chosen,
  output logic              out_switched,
  output logic [1:0]        out_status
);

  localparam int IW = $clog2(TASK_SLOTS);
  localparam int XW = (IW > SLOT_W) ? IW : SLOT_W;
  localparam logic [IW-1:0] LAST_IDX = IW'(TASK_SLOTS - 1);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_SCAN = 4'b0010,
    S_FILL = 4'b0100,
    S_FIN  = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  logic [TASK_SLOTS-1:0] pres_r, run_r, wv_r;
  slot_row_t             mem [TASK_SLOTS];
  slot_row_t             rd_data_r;

  logic [IW-1:0]     cur_r, cur_nxt;
  logic [IW-1:0]     rd_idx_r, rd_idx_nxt;
  logic              iss_r, iss_nxt;
  logic              cmp_vld_r, cmp_vld_nxt;
  logic [IW-1:0]     cmp_idx_r, cmp_idx_nxt;
  logic              cmp_cand_r, cmp_cand_nxt;
  logic              cmp_wv_r, cmp_wv_nxt;
  logic              best_vld_r, best_vld_nxt;
  logic [IW-1:0]     best_idx_r, best_idx_nxt;
  logic [CRED_W-1:0] best_cr_r, best_cr_nxt;
  status_t           res_st_r, res_st_nxt;
  logic              res_sw_r, res_sw_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [IW-1:0]     out_cur_r, out_cur_nxt;
  logic              out_sw_r, out_sw_nxt;
  status_t           out_st_r, out_st_nxt;

  logic              slot_we, exit_clr, mem_we;
  logic [IW-1:0]     mem_wa;
  slot_row_t         mem_wd;
  logic [XW-1:0]     slot_x, cur_x;
  logic [IW-1:0]     wr_idx;
  logic              in_range;
  logic [CRED_W-1:0] eff_cr, fill_cr, cand_cr;
  logic [PRIO_W-1:0] eff_pr;
  logic [CRED_W:0]   sum;

  assign slot_x   = XW'(in_slot);
  assign wr_idx   = slot_x[IW-1:0];
  assign in_range = 32'(in_slot) < 32'(TASK_SLOTS);
  assign cur_x    = XW'(out_cur_r);

  // rows never written read as their reset contents
  assign eff_cr  = cmp_wv_r ? rd_data_r.cred : '0;
  assign eff_pr  = cmp_wv_r ? rd_data_r.prio
                 : ((cmp_idx_r == '0) ? PRIO_SLOT0_RST : '0);
  assign sum     = {1'b0, eff_cr} + {1'b0, eff_pr};
  assign fill_cr = sum[CRED_W] ? {CRED_W{1'b1}} : sum[CRED_W-1:0];
  assign cand_cr = (state_r == S_FILL) ? fill_cr : eff_cr;

  always_comb begin
    state_nxt     = state_r;
    cur_nxt       = cur_r;
    rd_idx_nxt    = rd_idx_r;
    iss_nxt       = iss_r;
    cmp_vld_nxt   = 1'b0;
    cmp_idx_nxt   = rd_idx_r;
    cmp_cand_nxt  = pres_r[rd_idx_r] & run_r[rd_idx_r];
    cmp_wv_nxt    = wv_r[rd_idx_r];
    best_vld_nxt  = best_vld_r;
    best_idx_nxt  = best_idx_r;
    best_cr_nxt   = best_cr_r;
    res_st_nxt    = res_st_r;
    res_sw_nxt    = res_sw_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_cur_nxt   = out_cur_r;
    out_sw_nxt    = out_sw_r;
    out_st_nxt    = out_st_r;
    slot_we       = 1'b0;
    exit_clr      = 1'b0;
    mem_we        = 1'b0;
    mem_wa        = cmp_idx_r;
    mem_wd        = '{prio: eff_pr, cred: fill_cr};

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          res_st_nxt = ST_OK;
          res_sw_nxt = 1'b0;
          case (in_func)
            FN_WRITE: begin
              slot_we   = in_range;
              mem_we    = in_range;
              mem_wa    = wr_idx;
              mem_wd    = '{prio: in_priority_value, cred: in_credit_value};
              state_nxt = S_FIN;
            end
            FN_SCHED, FN_EXIT: begin
              exit_clr     = (in_func == FN_EXIT) && pres_r[cur_r];
              rd_idx_nxt   = '0;
              iss_nxt      = 1'b1;
              best_vld_nxt = 1'b0;
              state_nxt    = S_SCAN;
            end
            default: state_nxt = S_FIN;
          endcase
        end
      end
      S_SCAN, S_FILL: begin
        if (iss_r) begin
          cmp_vld_nxt = 1'b1;
          if (rd_idx_r == LAST_IDX) iss_nxt = 1'b0;
          else rd_idx_nxt = rd_idx_r + 1'b1;
        end
        if (cmp_vld_r && cmp_cand_r) begin
          mem_we = (state_r == S_FILL);
          // strict compare keeps the lowest index on a tie
          if (!best_vld_r || cand_cr > best_cr_r) begin
            best_vld_nxt = 1'b1;
            best_idx_nxt = cmp_idx_r;
            best_cr_nxt  = cand_cr;
          end
        end
        if (!iss_r && !cmp_vld_r) begin
          if (state_r == S_SCAN && !best_vld_r) begin
            res_st_nxt = ST_NONE;
            state_nxt  = S_FIN;
          end else if (state_r == S_SCAN && best_cr_r == '0) begin
            // every candidate is dry: refill and re-pick in one walk
            rd_idx_nxt   = '0;
            iss_nxt      = 1'b1;
            best_vld_nxt = 1'b0;
            state_nxt    = S_FILL;
          end else if (!best_vld_r || best_cr_r == '0) begin
            res_st_nxt = ST_NOCREDIT;
            state_nxt  = S_FIN;
          end else begin
            cur_nxt    = best_idx_r;
            res_sw_nxt = best_idx_r != cur_r;
            res_st_nxt = ST_OK;
            state_nxt  = S_FIN;
          end
        end
      end
      S_FIN: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_cur_nxt   = cur_r;
          out_sw_nxt    = res_sw_r;
          out_st_nxt    = res_st_r;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    rd_data_r <= mem[rd_idx_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pres_r <= {{(TASK_SLOTS-1){1'b0}}, 1'b1};
      run_r  <= {{(TASK_SLOTS-1){1'b0}}, 1'b1};
      wv_r   <= '0;
    end else begin
      if (slot_we) begin
        pres_r[wr_idx] <= in_slot_present;
        run_r[wr_idx]  <= in_slot_running;
      end
      if (exit_clr) run_r[cur_r] <= 1'b0;
      if (mem_we) wv_r[mem_wa] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cur_r       <= '0;
      rd_idx_r    <= '0;
      iss_r       <= 1'b0;
      cmp_vld_r   <= 1'b0;
      best_vld_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cur_r       <= cur_nxt;
      rd_idx_r    <= rd_idx_nxt;
      iss_r       <= iss_nxt;
      cmp_vld_r   <= cmp_vld_nxt;
      best_vld_r  <= best_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmp_idx_r  <= cmp_idx_nxt;
    cmp_cand_r <= cmp_cand_nxt;
    cmp_wv_r   <= cmp_wv_nxt;
    best_idx_r <= best_idx_nxt;
    best_cr_r  <= best_cr_nxt;
    res_st_r   <= res_st_nxt;
    res_sw_r   <= res_sw_nxt;
    out_cur_r  <= out_cur_nxt;
    out_sw_r   <= out_sw_nxt;
    out_st_r   <= out_st_nxt;
  end

  assign in_ready     = (state_r == S_IDLE);
  assign out_valid    = out_valid_r;
  assign out_chosen   = cur_x[SLOT_W-1:0];
  assign out_switched = out_sw_r;
  assign out_status   = out_st_r;

endmodule

### hw/rtl/crtp_checker.sv
module crtp_checker
  import crtp_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic [SLOT_W-1:0] out_chosen,
  input logic              out_switched,
  input logic [1:0]        out_status
);

  // a held result beat keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_chosen)
      && $stable(out_switched) && $stable(out_status))
    else $error("result beat changed while stalled");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == ST_OK || out_status == ST_NONE
      || out_status == ST_NOCREDIT))
    else $error("undefined status code");

  // a failed pick keeps the current slot
  a_switch_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_switched |-> out_status == ST_OK)
    else $error("switch reported with failing status");

  // one beat in flight at a time
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second beat taken while busy");

endmodule

bind credit_refill_task_picker crtp_checker u_crtp_checker (.*);
